@@ hdl/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants of the Modbus RTU response checker.
// Holds the beat structs, the frame layout constants and the CRC-16 step.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // Frame layout of a read-holding-registers response.
  localparam int FRAME_BYTES = 21;
  localparam int NUM_REGS    = 8;
  localparam int POS_W       = 5;
  localparam int REG_IDX_W   = 3;

  localparam logic [POS_W-1:0] POS_ADDR      = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FUNC      = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COUNT     = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DATA_LAST = POS_W'(2 + 2 * NUM_REGS);
  localparam logic [POS_W-1:0] POS_CRC_LO    = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_CRC_HI    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_DONE      = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_FIRST_LO  = POS_W'(4);

  // Protocol constants.
  localparam logic [15:0] CRC_PRESET        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  DATA_BYTE_COUNT   = 8'd16;

  // Input beat: one received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  // Result beat: status and the eight registers.
  typedef struct packed {
    logic               status;
    logic signed [15:0] temperature_tenths;
    logic [15:0]        humidity_tenths;
    logic [15:0]        conductivity;
    logic [15:0]        salinity;
    logic [15:0]        nitrogen;
    logic [15:0]        phosphorus;
    logic [15:0]        potassium;
    logic [15:0]        acidity_tenths;
  } out_t;

  // One byte of the Modbus CRC-16, LSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/modbus_rtu_response_checker_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit: Modbus RTU response checker, top level.
// Checks read-holding-registers responses and reports the eight registers.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready/in_data) takes one received byte per
// beat, with frame_start set on the first byte of a response. The output
// channel (out_valid/out_ready/out_data) gives one beat per complete frame,
// on its 21st byte: status 0 with the registers for a good frame, status 1
// and zero registers for a bad address, function, byte count or CRC.
// A byte enters an input register, is then processed by the frame tracker,
// and its result lands in the output register. One byte is taken per cycle
// unless stalled; the CRC step for a byte is a single pass of logic.
// When the receiver stalls with a result waiting, the byte in the input
// register holds, and in_ready drops once that register is full too.
// Reset (rst, synchronous) empties both registers, sets the expected address
// to 1 and makes the next byte frame byte 0. cfg_write_en writes the
// expected slave address from cfg_write_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);

  logic [7:0] expected_address;
  logic       stage_valid;
  in_t        stage_data;
  logic       advance;
  logic       res_valid;
  out_t       res_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= 8'd1;
    end else if (cfg_write_en) begin
      expected_address <= cfg_write_data;
    end
  end

  // The stage advances whenever the output register is free or draining.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

  mrc_frame u_frame (
    .clk              (clk),
    .rst              (rst),
    .enable           (advance),
    .item             (stage_data),
    .expected_address (expected_address),
    .result_valid     (res_valid),
    .result           (res_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_data;
    end
  end

`ifndef SYNTHESIS
  // A produced result always reaches the output register.
  a_res_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> out_valid)
    else $error("result lost");

  // The stage only stops taking bytes when it holds one.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid && out_valid && !out_ready)
    else $error("input stalled without cause");
`endif

endmodule

@@ hdl/mrc_frame.sv @@
// ----------------------------------------------------------------------------
// mrc_frame: frame tracker of the response checker.
// Keeps the byte position, CRC, header check and register store, and forms
// the result when the last byte of a frame is processed.
// ----------------------------------------------------------------------------
module mrc_frame
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       enable,
  input  in_t        item,
  input  logic [7:0] expected_address,
  output logic       result_valid,
  output out_t       result
);

  logic [POS_W-1:0] byte_position;
  logic [15:0]      crc_accumulator;
  logic             header_error;
  logic [7:0]       pending_high_byte;
  logic [7:0]       crc_low_byte;
  logic [15:0]      register_store [NUM_REGS];

  logic [POS_W-1:0] pos;
  logic [15:0]      crc_base;
  logic             hdr_base;
  logic [POS_W-1:0] store_off;
  logic [REG_IDX_W-1:0] store_idx;
  logic             in_data;
  logic             bad;

  // A frame start restarts position, CRC and header check.
  assign pos       = item.frame_start ? POS_ADDR : byte_position;
  assign crc_base  = item.frame_start ? CRC_PRESET : crc_accumulator;
  assign hdr_base  = item.frame_start ? 1'b0 : header_error;
  assign store_off = pos - POS_FIRST_LO;
  assign store_idx = store_off[REG_IDX_W:1];
  assign in_data   = (pos > POS_COUNT) && (pos <= POS_DATA_LAST);

  // Frame state update on each processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_ADDR;
      crc_accumulator <= CRC_PRESET;
      header_error    <= 1'b0;
    end else if (enable) begin
      byte_position   <= pos;
      crc_accumulator <= crc_base;
      header_error    <= hdr_base;
      if (pos < POS_DONE) begin
        byte_position <= pos + POS_W'(1);
        if (pos < POS_CRC_LO) begin
          crc_accumulator <= crc_update(crc_base, item.rx_byte);
        end
        if (pos == POS_ADDR) begin
          header_error <= (item.rx_byte != expected_address);
        end else if (pos == POS_FUNC) begin
          header_error <= hdr_base | (item.rx_byte != FUNC_READ_HOLDING);
        end else if (pos == POS_COUNT) begin
          header_error <= hdr_base | (item.rx_byte != DATA_BYTE_COUNT);
        end
      end
    end
  end

  // Pending high data byte and the low CRC byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high_byte <= 8'h00;
      crc_low_byte      <= 8'h00;
    end else if (enable) begin
      if (in_data && pos[0]) begin
        pending_high_byte <= item.rx_byte;
      end
      if (pos == POS_CRC_LO) begin
        crc_low_byte <= item.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable && in_data && !pos[0]) begin
      register_store[store_idx] <= {pending_high_byte, item.rx_byte};
    end
  end

  // Result on the high CRC byte; an invalid frame reports zero registers.
  assign result_valid = enable && (pos == POS_CRC_HI);
  assign bad = hdr_base || ({item.rx_byte, crc_low_byte} != crc_base);

  always_comb begin
    result.status             = bad;
    result.temperature_tenths = bad ? 16'sd0 : $signed(register_store[0]);
    result.humidity_tenths    = bad ? 16'd0 : register_store[1];
    result.conductivity       = bad ? 16'd0 : register_store[2];
    result.salinity           = bad ? 16'd0 : register_store[3];
    result.nitrogen           = bad ? 16'd0 : register_store[4];
    result.phosphorus         = bad ? 16'd0 : register_store[5];
    result.potassium          = bad ? 16'd0 : register_store[6];
    result.acidity_tenths     = bad ? 16'd0 : register_store[7];
  end

`ifndef SYNTHESIS
  // The position never runs past the idle mark after a completed frame.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_DONE)
    else $error("byte position out of range");

  // A completed frame leaves the tracker idle until the next frame start.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> byte_position == POS_DONE)
    else $error("tracker not idle after result");
`endif

endmodule
